// ----- rtl/core/dph_pkg.sv -----
// Shared types and constants for the deadline priority heap.
// No dependencies; compiled first.
package dph_pkg;

    // Field widths fixed by the request and result formats
    localparam int KEY_W      = 33;
    localparam int TIME_W     = 32;
    localparam int ID_IN_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Request operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURNOUT    = 1'd1;

    // Scheduling modes
    localparam logic MODE_FIFO     = 1'b0;
    localparam logic MODE_DEADLINE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_READ,
        S_DN_CMP,
        S_FINISH
    } dph_state_t;

    // Sift-down choice among the moving entry and its two children
    typedef enum logic [1:0] {
        PICK_SELF,
        PICK_LEFT,
        PICK_RIGHT
    } dph_pick_t;

endpackage

// ----- rtl/core/dph_if.sv -----
// Valid/ready channel interfaces for heap requests and results.
// Depends on dph_pkg for field widths.
interface dph_req_if;
    import dph_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [ID_IN_W-1:0] requester_id;
    logic [TIME_W-1:0]  now_time;
    logic [TIME_W-1:0]  last_start;

    modport source (output valid, req_type, requester_id, now_time, last_start,
                    input ready);
    modport sink (input valid, req_type, requester_id, now_time, last_start,
                  output ready);
endinterface

interface dph_rsp_if;
    import dph_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    top_key;
    logic [ID_IN_W-1:0]  top_id;

    modport source (output valid, status, top_key, top_id, input ready);
    modport sink (input valid, status, top_key, top_id, output ready);
endinterface

// ----- rtl/core/dph_select.sv -----
// Sift-down selector: picks the smallest of a node and its two children.
// Entries are {key, id}, so one unsigned compare orders key then id.
// Depends on dph_pkg.
module dph_select #(
    parameter int ID_BITS = 8
) (
    input  logic [dph_pkg::KEY_W+ID_BITS-1:0] node,
    input  logic [dph_pkg::KEY_W+ID_BITS-1:0] left,
    input  logic [dph_pkg::KEY_W+ID_BITS-1:0] right,
    input  logic                              left_ok,
    input  logic                              right_ok,
    output dph_pkg::dph_pick_t                pick
);
    import dph_pkg::*;

    localparam int ENTRY_W = KEY_W + ID_BITS;

    logic               left_wins;
    logic [ENTRY_W-1:0] cand;
    logic               right_wins;

    // Left against the node, then right against the survivor
    always_comb
    begin
        left_wins  = left_ok && (left < node);
        cand       = left_wins ? left : node;
        right_wins = right_ok && (right < cand);
        priority if (right_wins)
            pick = PICK_RIGHT;
        else if (left_wins)
            pick = PICK_LEFT;
        else
            pick = PICK_SELF;
    end

endmodule

// ----- rtl/core/deadline_priority_heap.sv -----
// Deadline priority heap: binary min-heap of {key, id} in one synchronous RAM.
// Push: the entry climbs one level per parent compare (at most the heap depth) and is
// written directly when the heap was empty. Pop: root and last entry are read together, then each
// level descended is a child read and a compare. A refused push or pop goes straight to the result.
// One request in flight; the next transfer is taken the cycle after the result loads.
// Reset clears the entry count, mode registers and handshake state; RAM is not cleared.
module deadline_priority_heap #(
    parameter int MAX_ENTRIES = 64,
    parameter int ID_BITS     = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dph_pkg::CFG_DATA_W-1:0]   cfg_data,
    dph_req_if.sink                          req,
    dph_rsp_if.source                        rsp
);
    import dph_pkg::*;

    localparam int ENTRY_W = KEY_W + ID_BITS;
    localparam int AW      = $clog2(MAX_ENTRIES);
    localparam int CW      = $clog2(MAX_ENTRIES + 1);
    localparam int XW      = AW + 2;
    localparam int IDX_EXT = (ID_BITS > ID_IN_W) ? ID_BITS : ID_IN_W;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_ENTRIES);

    // Heap RAM: one write port, two registered read ports
    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] rd_a_data_reg;
    logic [ENTRY_W-1:0] rd_b_data_reg;
    logic [AW-1:0]      rd_a_addr;
    logic [AW-1:0]      rd_b_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Control and datapath registers
    dph_state_t          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [ENTRY_W-1:0]  mov_reg, mov_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [ID_BITS-1:0]  res_id_reg, res_id_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic [ID_BITS-1:0]  out_id_reg;
    logic                out_load;
    logic                mode_reg;
    logic [TIME_W-1:0]   burnout_reg;

    // Helpers
    logic               in_xfer;
    logic [KEY_W-1:0]   new_key;
    logic [IDX_EXT-1:0] new_id_ext;
    logic [ENTRY_W-1:0] new_entry;
    logic [AW-1:0]      push_parent;
    logic [AW-1:0]      up_parent;
    logic [AW-1:0]      up_grand;
    logic [XW-1:0]      left_x;
    logic [XW-1:0]      right_x;
    logic [XW-1:0]      count_x;
    logic               left_ok;
    logic               right_ok;
    dph_pick_t          pick;
    logic [IDX_EXT-1:0] out_id_ext;

    assign req.ready = (state_reg == S_IDLE);
    assign in_xfer   = req.valid && req.ready;

    // Form the key from the scheduling mode
    always_comb
    begin
        if (mode_reg == MODE_DEADLINE)
            new_key = {1'b0, req.last_start} + {1'b0, burnout_reg};
        else
            new_key = {1'b0, req.now_time};
        new_id_ext = IDX_EXT'(req.requester_id);
        new_entry  = {new_key, new_id_ext[ID_BITS-1:0]};
    end

    // Index arithmetic for parents and children
    assign push_parent = (count_reg[AW-1:0] - AW'(1)) >> 1;
    assign up_parent   = (idx_reg - AW'(1)) >> 1;
    assign up_grand    = (up_parent - AW'(1)) >> 1;
    assign left_x      = {1'b0, idx_reg, 1'b1};
    assign right_x     = left_x + XW'(1);
    assign count_x     = XW'(count_reg);
    assign left_ok     = left_x < count_x;
    assign right_ok    = right_x < count_x;

    dph_select #(
        .ID_BITS (ID_BITS)
    ) u_select (
        .node     (mov_reg),
        .left     (rd_a_data_reg),
        .right    (rd_b_data_reg),
        .left_ok  (left_ok),
        .right_ok (right_ok),
        .pick     (pick)
    );

    // Sequencer: next state, memory accesses and datapath updates
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        mov_next        = mov_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_id_next     = res_id_reg;
        rd_a_addr       = left_x[AW-1:0];
        rd_b_addr       = right_x[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = mov_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_a_addr = push_parent;
                if (in_xfer)
                begin
                    res_status_next = STATUS_OK;
                    res_key_next    = '0;
                    res_id_next     = '0;
                    if (req.req_type == OP_PUSH)
                    begin
                        if (count_reg == COUNT_FULL)
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            mov_next   = new_entry;
                            idx_next   = count_reg[AW-1:0];
                            if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = new_entry;
                                state_next = S_FINISH;
                            end
                            else
                                state_next = S_UP_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            // Fetch root and last entry together
                            rd_a_addr  = '0;
                            rd_b_addr  = AW'(count_reg - CW'(1));
                            count_next = count_reg - CW'(1);
                            state_next = S_DN_LOAD;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                // Parent data is in port A; fetch the grandparent meanwhile
                rd_a_addr = up_grand;
                if (idx_reg == '0 || !(mov_reg < rd_a_data_reg))
                begin
                    wr_en      = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_a_data_reg;
                    idx_next = up_parent;
                end
            end

            S_DN_LOAD:
            begin
                res_key_next = rd_a_data_reg[ENTRY_W-1:ID_BITS];
                res_id_next  = rd_a_data_reg[ID_BITS-1:0];
                mov_next     = rd_b_data_reg;
                idx_next     = '0;
                if (count_reg == '0)
                    state_next = S_FINISH;
                else
                    state_next = S_DN_READ;
            end

            S_DN_READ:
            begin
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                unique case (pick)
                    PICK_LEFT:
                    begin
                        wr_data    = rd_a_data_reg;
                        idx_next   = left_x[AW-1:0];
                        state_next = S_DN_READ;
                    end
                    PICK_RIGHT:
                    begin
                        wr_data    = rd_b_data_reg;
                        idx_next   = right_x[AW-1:0];
                        state_next = S_DN_READ;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, drop after transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // Heap RAM
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_data_reg <= mem[rd_a_addr];
        rd_b_data_reg <= mem[rd_b_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_FIFO;
            burnout_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SCHED_MODE: mode_reg    <= cfg_data[0];
                    REG_BURNOUT:    burnout_reg <= cfg_data;
                    default:        mode_reg    <= mode_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        mov_reg        <= mov_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_id_reg     <= res_id_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_id_reg     <= res_id_reg;
        end
    end

    // Drive the result channel
    assign out_id_ext  = IDX_EXT'(out_id_reg);
    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.top_key = out_key_reg;
    assign rsp.top_id  = out_id_ext[ID_IN_W-1:0];

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for deadline_priority_heap: a heap mirror predicts every result.
// Depends on dph_pkg, the dph_req_if/dph_rsp_if interfaces and the heap RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dph_pkg::*;

    localparam int MAX_ENTRIES  = 64;
    localparam int ID_BITS      = 8;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 272;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ID_BITS-1:0] id;
    } heap_entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [ID_IN_W-1:0]  id;
    } heap_result_t;

    // Mirror of the heap contents plus the queue of results still owed by the block
    class heap_mirror;
        heap_entry_t    slots [MAX_ENTRIES];
        int unsigned    count;
        logic           mode;
        logic [31:0]    burnout;
        heap_result_t   pending [$];
        int unsigned    errors;

        function new();
            count   = 0;
            mode    = MODE_FIFO;
            burnout = '0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SCHED_MODE)
                mode = data[0];
            else if (idx == REG_BURNOUT)
                burnout = data;
        endfunction

        // Smaller key first, smaller id on equal keys
        function bit earlier(heap_entry_t a, heap_entry_t b);
            if (a.key != b.key)
                return a.key < b.key;
            return a.id < b.id;
        endfunction

        // Apply one accepted request to the mirror and queue its result
        function void note_request(logic op, logic [ID_IN_W-1:0] id,
                                   logic [TIME_W-1:0] now_t, logic [TIME_W-1:0] start);
            heap_entry_t  e;
            heap_entry_t  tmp;
            heap_result_t res;
            int unsigned  i;
            int unsigned  p;
            int unsigned  l;
            int unsigned  r;
            int unsigned  best;
            res = '{status: STATUS_OK, key: '0, id: '0};
            if (op == OP_PUSH) begin
                if (count >= MAX_ENTRIES) begin
                    res.status = STATUS_FULL;
                end else begin
                    if (mode == MODE_FIFO)
                        e.key = {1'b0, now_t};
                    else
                        e.key = {1'b0, start} + {1'b0, burnout};
                    e.id = id[ID_BITS-1:0];
                    i = count;
                    slots[i] = e;
                    count++;
                    // sift up
                    while (i > 0) begin
                        p = (i - 1) / 2;
                        if (!earlier(slots[i], slots[p]))
                            break;
                        tmp = slots[i];
                        slots[i] = slots[p];
                        slots[p] = tmp;
                        i = p;
                    end
                end
            end else begin
                if (count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.key = slots[0].key;
                    res.id  = ID_IN_W'(slots[0].id);
                    count--;
                    slots[0] = slots[count];
                    i = 0;
                    // sift down
                    forever begin
                        l = 2 * i + 1;
                        r = 2 * i + 2;
                        best = i;
                        if (l < count && earlier(slots[l], slots[best]))
                            best = l;
                        if (r < count && earlier(slots[r], slots[best]))
                            best = r;
                        if (best == i)
                            break;
                        tmp = slots[i];
                        slots[i] = slots[best];
                        slots[best] = tmp;
                        i = best;
                    end
                end
            end
            pending.push_back(res);
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_CAP)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result transfer with the oldest queued result
        task check_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] key,
                          logic [ID_IN_W-1:0] id);
            heap_result_t exp_res;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d key=%0h id=%0d",
                                          st, key, id));
            end else begin
                exp_res = pending.pop_front();
                if (st !== exp_res.status)
                    report_mismatch($sformatf("status got %0d want %0d", st, exp_res.status));
                if (key !== exp_res.key)
                    report_mismatch($sformatf("top_key got %0h want %0h", key, exp_res.key));
                if (id !== exp_res.id)
                    report_mismatch($sformatf("top_id got %0d want %0d", id, exp_res.id));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    idle_on;
    logic [TIME_W-1:0]     now_ms;
    int unsigned           cycle_count = 0;
    heap_mirror            sb;

    dph_req_if req_ch ();
    dph_rsp_if rsp_ch ();

    deadline_priority_heap #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.status, rsp_ch.top_key, rsp_ch.top_id);
    end

    // Stall the result side in random bursts
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    function automatic logic [TIME_W-1:0] random_ms(logic [TIME_W-1:0] base);
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $urandom_range(0, 15);
            2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return base;
        endcase
    endfunction

    function automatic logic [ID_IN_W-1:0] random_id();
        case ($urandom_range(0, 3))
            0:       return ID_IN_W'($urandom_range(0, 3));
            1:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default: return ID_IN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one request and hold it until the transfer
    task automatic send_request(input logic op, input logic [ID_IN_W-1:0] id,
                                input logic [TIME_W-1:0] now_t,
                                input logic [TIME_W-1:0] start);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= op;
        req_ch.requester_id <= id;
        req_ch.now_time     <= now_t;
        req_ch.last_start   <= start;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(op, id, now_t, start);
    endtask

    // Drop valid and wait until every owed result has arrived
    task automatic wait_for_drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int unsigned     phase;
        int unsigned     n;
        int unsigned     seg_left;
        int unsigned     push_pct;
        logic            mode_sel;
        logic [31:0]     burn;
        logic            op;

        sb                  = new();
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_SCHED_MODE;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = OP_PUSH;
        req_ch.requester_id = '0;
        req_ch.now_time     = '0;
        req_ch.last_start   = '0;
        idle_on             = 1'b1;
        now_ms              = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        // Directed: fifo keys at the extremes, ties on key, pops past empty
        write_reg(REG_SCHED_MODE, {31'd0, MODE_FIFO});
        write_reg(REG_BURNOUT, 32'd0);
        send_request(OP_POP, 8'd0, 32'd0, 32'd0);
        send_request(OP_PUSH, 8'd255, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_PUSH, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 8'd7, 32'd0, 32'd0);
        send_request(OP_PUSH, 8'd3, 32'd0, 32'd0);
        send_request(OP_PUSH, 8'd128, 32'h8000_0000, 32'd0);
        repeat (6) send_request(OP_POP, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_for_drain();

        // Directed: deadline keys with the widest sum and a tie on it
        write_reg(REG_SCHED_MODE, {31'h7FFF_FFFF, MODE_DEADLINE});
        write_reg(REG_BURNOUT, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 8'd1, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 8'd2, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_PUSH, 8'd0, 32'd5, 32'hFFFF_FFFF);
        repeat (4) send_request(OP_POP, 8'd0, 32'd0, 32'd0);

        // Random phases: fill, drain and mixed segments under several settings
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_drain();
            case (phase)
                0:       begin mode_sel = MODE_FIFO;     burn = 32'd0;         end
                1:       begin mode_sel = MODE_DEADLINE; burn = 32'd0;         end
                2:       begin mode_sel = MODE_DEADLINE; burn = 32'hFFFF_FFFF; end
                3:       begin mode_sel = MODE_FIFO;     burn = $urandom;      end
                4:       begin mode_sel = MODE_DEADLINE; burn = $urandom;      end
                default: begin mode_sel = MODE_DEADLINE; burn = $urandom_range(0, 1000); end
            endcase
            write_reg(REG_SCHED_MODE, {31'($urandom), mode_sel});
            write_reg(REG_BURNOUT, burn);
            idle_on  = (phase != NUM_PHASES - 1);
            seg_left = 0;
            push_pct = 50;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(30, 140);
                    case ($urandom_range(0, 2))
                        0:       push_pct = 85;
                        1:       push_pct = 15;
                        default: push_pct = 50;
                    endcase
                end
                seg_left--;
                // hold off once mid-phase until the block has answered everything
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    wait_for_drain();
                now_ms = now_ms + $urandom_range(0, 3);
                op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
                send_request(op, random_id(), random_ms(now_ms),
                             random_ms(now_ms - $urandom_range(0, 2000)));
            end
        end

        wait_for_drain();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/dph_pkg.sv
rtl/core/dph_if.sv
rtl/core/dph_select.sv
rtl/core/deadline_priority_heap.sv
verif/testbench.sv
